>>> rtl/core/rtsss_pkg.sv
// ----------------------------------------------------------------------------
// rtsss_pkg: shared types, codes and microcode for the segment splitter
// Request/result structs, status and opcode codes, control word format and
// the read-only control program run by the sequencer.
// ----------------------------------------------------------------------------
package rtsss_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned FIELD_W  = 48;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned STEP_W   = 5;

  // request opcodes
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SEGMENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd3;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [FIELD_W-1:0]  subfile_length;
    logic [FIELD_W-1:0]  range_first;
    logic [FIELD_W-1:0]  range_last;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    subfile_index;
    logic [FIELD_W-1:0]  segment_first;
    logic [FIELD_W-1:0]  segment_last;
    logic                last_result;
  } res_t;

  // datapath actions
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_TAKE,
    ACT_CLEAR,
    ACT_APPEND,
    ACT_EMIT_OK,
    ACT_EMIT_REJECT,
    ACT_QINIT,
    ACT_READ,
    ACT_LOAD,
    ACT_CALC_E,
    ACT_PUSH,
    ACT_NEXT,
    ACT_EMIT_FINAL
  } act_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_VALID,
    C_OP_QUERY,
    C_OP_APPEND,
    C_OP_CLEAR,
    C_APPEND_BAD,
    C_RANGE_BAD,
    C_WALK_DONE,
    C_EMPTY,
    C_BEYOND,
    C_MISS,
    C_OUT_BUSY,
    C_PUSH_STALL
  } cond_e;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t target;
  } ucode_t;

  // status flags from datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic op_query;
    logic op_append;
    logic op_clear;
    logic append_bad;
    logic range_bad;
    logic walk_done;
    logic empty;
    logic beyond;
    logic miss;
    logic out_busy;
    logic push_stall;
  } flags_t;

  // program addresses
  localparam step_t S_IDLE    = 5'd0;
  localparam step_t S_DISP0   = 5'd1;
  localparam step_t S_DISP1   = 5'd2;
  localparam step_t S_DISP2   = 5'd3;
  localparam step_t S_REJECT  = 5'd4;
  localparam step_t S_REJ_RET = 5'd5;
  localparam step_t S_CLEAR   = 5'd6;
  localparam step_t S_ACK     = 5'd7;
  localparam step_t S_ACK_RET = 5'd8;
  localparam step_t S_APPCHK  = 5'd9;
  localparam step_t S_APPWR   = 5'd10;
  localparam step_t S_QINIT   = 5'd11;
  localparam step_t S_QREAD   = 5'd12;
  localparam step_t S_QLOAD   = 5'd13;
  localparam step_t S_QCALC   = 5'd14;
  localparam step_t S_QBEYOND = 5'd15;
  localparam step_t S_QMISS   = 5'd16;
  localparam step_t S_QPUSH   = 5'd17;
  localparam step_t S_QNEXT   = 5'd18;
  localparam step_t S_QEND    = 5'd19;
  localparam step_t S_QRET    = 5'd20;

  function automatic ucode_t uw(input act_e a, input cond_e c, input step_t t);
    ucode_t w;
    w.act    = a;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // control store: jump to target when cond holds, else fall through
  function automatic ucode_t ucode(input step_t step);
    ucode_t cw;
    unique case (step)
      S_IDLE:    cw = uw(ACT_TAKE,        C_NO_VALID,   S_IDLE);
      S_DISP0:   cw = uw(ACT_NOP,         C_OP_QUERY,   S_QINIT);
      S_DISP1:   cw = uw(ACT_NOP,         C_OP_APPEND,  S_APPCHK);
      S_DISP2:   cw = uw(ACT_NOP,         C_OP_CLEAR,   S_CLEAR);
      S_REJECT:  cw = uw(ACT_EMIT_REJECT, C_OUT_BUSY,   S_REJECT);
      S_REJ_RET: cw = uw(ACT_NOP,         C_ALWAYS,     S_IDLE);
      S_CLEAR:   cw = uw(ACT_CLEAR,       C_ALWAYS,     S_ACK);
      S_ACK:     cw = uw(ACT_EMIT_OK,     C_OUT_BUSY,   S_ACK);
      S_ACK_RET: cw = uw(ACT_NOP,         C_ALWAYS,     S_IDLE);
      S_APPCHK:  cw = uw(ACT_NOP,         C_APPEND_BAD, S_REJECT);
      S_APPWR:   cw = uw(ACT_APPEND,      C_ALWAYS,     S_ACK);
      S_QINIT:   cw = uw(ACT_QINIT,       C_RANGE_BAD,  S_QEND);
      S_QREAD:   cw = uw(ACT_READ,        C_WALK_DONE,  S_QEND);
      S_QLOAD:   cw = uw(ACT_LOAD,        C_NEVER,      S_IDLE);
      S_QCALC:   cw = uw(ACT_CALC_E,      C_EMPTY,      S_QNEXT);
      S_QBEYOND: cw = uw(ACT_NOP,         C_BEYOND,     S_QEND);
      S_QMISS:   cw = uw(ACT_NOP,         C_MISS,       S_QNEXT);
      S_QPUSH:   cw = uw(ACT_PUSH,        C_PUSH_STALL, S_QPUSH);
      S_QNEXT:   cw = uw(ACT_NEXT,        C_ALWAYS,     S_QREAD);
      S_QEND:    cw = uw(ACT_EMIT_FINAL,  C_OUT_BUSY,   S_QEND);
      S_QRET:    cw = uw(ACT_NOP,         C_ALWAYS,     S_IDLE);
      default:   cw = uw(ACT_NOP,         C_ALWAYS,     S_IDLE);
    endcase
    return cw;
  endfunction

endpackage

>>> rtl/core/rtsss_ram.sv
// ----------------------------------------------------------------------------
// rtsss_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rtsss_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/rtsss_seq.sv
// ----------------------------------------------------------------------------
// rtsss_seq: microcode sequencer
// Step counter, control store fetch and conditional jump selection.
// ----------------------------------------------------------------------------
module rtsss_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rtsss_pkg::flags_t flags_i,
  output rtsss_pkg::act_e   act_o
);

  rtsss_pkg::step_t  step_d, step_q;
  rtsss_pkg::ucode_t cw;
  logic              take;

  always_comb begin
    cw = rtsss_pkg::ucode(step_q);
    unique case (cw.cond)
      rtsss_pkg::C_NEVER:      take = 1'b0;
      rtsss_pkg::C_ALWAYS:     take = 1'b1;
      rtsss_pkg::C_NO_VALID:   take = ~flags_i.in_valid;
      rtsss_pkg::C_OP_QUERY:   take = flags_i.op_query;
      rtsss_pkg::C_OP_APPEND:  take = flags_i.op_append;
      rtsss_pkg::C_OP_CLEAR:   take = flags_i.op_clear;
      rtsss_pkg::C_APPEND_BAD: take = flags_i.append_bad;
      rtsss_pkg::C_RANGE_BAD:  take = flags_i.range_bad;
      rtsss_pkg::C_WALK_DONE:  take = flags_i.walk_done;
      rtsss_pkg::C_EMPTY:      take = flags_i.empty;
      rtsss_pkg::C_BEYOND:     take = flags_i.beyond;
      rtsss_pkg::C_MISS:       take = flags_i.miss;
      rtsss_pkg::C_OUT_BUSY:   take = flags_i.out_busy;
      rtsss_pkg::C_PUSH_STALL: take = flags_i.push_stall;
      default:                 take = 1'b0;
    endcase
    step_d = take ? cw.target : rtsss_pkg::step_t'(step_q + 1'b1);
  end

  assign act_o = cw.act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= rtsss_pkg::S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

>>> rtl/core/rtsss_dp.sv
// ----------------------------------------------------------------------------
// rtsss_dp: splitter datapath
// Request latch, subfile table RAM, walk registers, pending segment and
// output register, driven by one action per cycle from the sequencer.
// ----------------------------------------------------------------------------
module rtsss_dp #(
  parameter int unsigned MAX_SUBFILES = 16,
  parameter int unsigned OFFSET_BITS  = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rtsss_pkg::act_e   act_i,
  output rtsss_pkg::flags_t flags_o,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rtsss_pkg::req_t   in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rtsss_pkg::res_t   out_res_o
);

  localparam int unsigned IW = $clog2(MAX_SUBFILES + 1);
  localparam int unsigned AW = (MAX_SUBFILES > 1) ? $clog2(MAX_SUBFILES) : 1;
  localparam int unsigned EW = 2 * OFFSET_BITS;

  typedef logic [OFFSET_BITS-1:0] off_t;

  // latched request
  logic [rtsss_pkg::OPCODE_W-1:0] op_d, op_q;
  off_t len_d, len_q, rf_d, rf_q, rl_d, rl_q;

  // table bookkeeping and walk state
  logic [IW-1:0] count_d, count_q, idx_d, idx_q;
  off_t          total_d, total_q;
  off_t          s_d, s_q, l_d, l_q, e_d, e_q;
  logic [OFFSET_BITS:0] sum;

  // pending segment, held until the next one shows whether it is final
  logic                        pend_d, pend_q;
  logic [rtsss_pkg::IDX_W-1:0] pend_idx_d, pend_idx_q;
  off_t                        pend_first_d, pend_first_q, pend_last_d, pend_last_q;
  off_t                        seg_first, seg_last;

  logic            out_valid_d, out_valid_q;
  rtsss_pkg::res_t out_d, out_q, res;
  logic            emit, out_busy, push_stall;

  logic          ram_we;
  logic [EW-1:0] ram_rdata;

  rtsss_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_SUBFILES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i({total_q, len_q}),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign sum        = {1'b0, total_q} + {1'b0, len_q};
  assign out_busy   = out_valid_q & ~out_ready_i;
  assign push_stall = pend_q & out_busy;
  assign in_ready_o = (act_i == rtsss_pkg::ACT_TAKE);
  assign ram_we     = (act_i == rtsss_pkg::ACT_APPEND);

  // clipped segment, relative to the subfile start
  assign seg_first = (s_q > rf_q) ? '0 : off_t'(rf_q - s_q);
  assign seg_last  = (e_q < rl_q) ? off_t'(l_q - 1'b1) : off_t'(rl_q - s_q);

  always_comb begin
    flags_o.in_valid   = in_valid_i;
    flags_o.op_query   = (op_q == rtsss_pkg::OP_QUERY);
    flags_o.op_append  = (op_q == rtsss_pkg::OP_APPEND);
    flags_o.op_clear   = (op_q == rtsss_pkg::OP_CLEAR);
    flags_o.append_bad = (count_q == IW'(MAX_SUBFILES)) | sum[OFFSET_BITS];
    flags_o.range_bad  = (rf_q > rl_q);
    flags_o.walk_done  = (idx_q == count_q);
    flags_o.empty      = (l_q == '0);
    flags_o.beyond     = (s_q > rl_q);
    flags_o.miss       = (e_q < rf_q);
    flags_o.out_busy   = out_busy;
    flags_o.push_stall = push_stall;
  end

  // result selection
  always_comb begin
    emit = 1'b0;
    res  = '0;
    unique case (act_i)
      rtsss_pkg::ACT_EMIT_OK: begin
        emit            = ~out_busy;
        res.status      = rtsss_pkg::ST_OK;
        res.last_result = 1'b1;
      end
      rtsss_pkg::ACT_EMIT_REJECT: begin
        emit            = ~out_busy;
        res.status      = rtsss_pkg::ST_REJECT;
        res.last_result = 1'b1;
      end
      rtsss_pkg::ACT_PUSH,
      rtsss_pkg::ACT_EMIT_FINAL: begin
        emit = ~out_busy & (pend_q | (act_i == rtsss_pkg::ACT_EMIT_FINAL));
        if (pend_q) begin
          res.status        = rtsss_pkg::ST_SEGMENT;
          res.subfile_index = pend_idx_q;
          res.segment_first = rtsss_pkg::FIELD_W'(pend_first_q);
          res.segment_last  = rtsss_pkg::FIELD_W'(pend_last_q);
        end else begin
          res.status = rtsss_pkg::ST_NONE;
        end
        res.last_result = (act_i == rtsss_pkg::ACT_EMIT_FINAL);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // next-state logic
  always_comb begin
    op_d         = op_q;
    len_d        = len_q;
    rf_d         = rf_q;
    rl_d         = rl_q;
    count_d      = count_q;
    total_d      = total_q;
    idx_d        = idx_q;
    s_d          = s_q;
    l_d          = l_q;
    e_d          = e_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    pend_first_d = pend_first_q;
    pend_last_d  = pend_last_q;

    unique case (act_i)
      rtsss_pkg::ACT_TAKE: begin
        if (in_valid_i) begin
          op_d  = in_req_i.opcode;
          len_d = off_t'(in_req_i.subfile_length);
          rf_d  = off_t'(in_req_i.range_first);
          rl_d  = off_t'(in_req_i.range_last);
        end
      end
      rtsss_pkg::ACT_CLEAR: begin
        count_d = '0;
        total_d = '0;
      end
      rtsss_pkg::ACT_APPEND: begin
        count_d = IW'(count_q + 1'b1);
        total_d = sum[OFFSET_BITS-1:0];
      end
      rtsss_pkg::ACT_QINIT: begin
        idx_d  = '0;
        pend_d = 1'b0;
      end
      rtsss_pkg::ACT_LOAD: begin
        s_d = ram_rdata[EW-1:OFFSET_BITS];
        l_d = ram_rdata[OFFSET_BITS-1:0];
      end
      rtsss_pkg::ACT_CALC_E: begin
        // last byte of a non-empty entry; cannot wrap, total never overflows
        e_d = off_t'(s_q + l_q - 1'b1);
      end
      rtsss_pkg::ACT_PUSH: begin
        if (!push_stall) begin
          pend_d       = 1'b1;
          pend_idx_d   = rtsss_pkg::IDX_W'(idx_q);
          pend_first_d = seg_first;
          pend_last_d  = seg_last;
        end
      end
      rtsss_pkg::ACT_NEXT: begin
        idx_d = IW'(idx_q + 1'b1);
      end
      rtsss_pkg::ACT_EMIT_FINAL: begin
        if (!out_busy) begin
          pend_d = 1'b0;
        end
      end
      default: begin
        pend_d = pend_q;
      end
    endcase

    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    out_d       = emit ? res : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      total_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      op_q        <= rtsss_pkg::OP_CLEAR;
    end else begin
      count_q     <= count_d;
      total_q     <= total_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q        <= len_d;
    rf_q         <= rf_d;
    rl_q         <= rl_d;
    s_q          <= s_d;
    l_q          <= l_d;
    e_q          <= e_d;
    pend_idx_q   <= pend_idx_d;
    pend_first_q <= pend_first_d;
    pend_last_q  <= pend_last_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

>>> rtl/core/range_to_subfile_segment_splitter.sv
// Query: the microcode loop walks the table one entry per pass through
// the single RAM read port. One request in flight at a time.
// Reset: table empty and running total zero; table RAM contents are not
// cleared, and no entry at or above the count is ever read.
// ----------------------------------------------------------------------------
// range_to_subfile_segment_splitter: subfile table and range splitter
// Keeps an ordered table of subfile lengths and splits a byte range of the
// concatenated space into per-subfile segments.
// ----------------------------------------------------------------------------
module range_to_subfile_segment_splitter #(
  parameter int unsigned MAX_SUBFILES = 16,
  parameter int unsigned OFFSET_BITS  = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rtsss_pkg::req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rtsss_pkg::res_t out_res_o
);

  rtsss_pkg::act_e   act;
  rtsss_pkg::flags_t flags;

  rtsss_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flags_i(flags),
    .act_o  (act)
  );

  rtsss_dp #(
    .MAX_SUBFILES(MAX_SUBFILES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .act_i      (act),
    .flags_o    (flags),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for range_to_subfile_segment_splitter
// Runs a short table of directed requests, then random clear/append/query
// sequences with bursty requests and a stalling result side. Every result is
// checked against a local table/split predictor, in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned TABLE_DEPTH  = 16;
  localparam int unsigned RANDOM_ITEMS = 320;
  localparam logic [rtsss_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [rtsss_pkg::FIELD_W-1:0]  FULL48    = {rtsss_pkg::FIELD_W{1'b1}};

  typedef struct {
    rtsss_pkg::req_t                req;
    bit                             typed;
    logic [rtsss_pkg::STATUS_W-1:0] want_status;
  } dir_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  rtsss_pkg::req_t in_req_i;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  rtsss_pkg::res_t out_res_o;

  // side-band tags that travel with the request being offered
  bit                             row_typed;
  logic [rtsss_pkg::STATUS_W-1:0] row_status;

  // predictor state
  logic [rtsss_pkg::FIELD_W-1:0] sub_start [TABLE_DEPTH];
  logic [rtsss_pkg::FIELD_W-1:0] sub_len   [TABLE_DEPTH];
  int unsigned                   sub_count;
  logic [rtsss_pkg::FIELD_W-1:0] byte_total;

  rtsss_pkg::res_t split_expect[$];

  int unsigned fail_count, n_sent, n_results, n_segments, n_none, n_reject;
  int unsigned burst_left, stall_left, stall_pct;

  always #10 clk_i = ~clk_i;

  range_to_subfile_segment_splitter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [rtsss_pkg::FIELD_W-1:0] rand48();
    logic [63:0] v;
    v = rand64();
    return v[rtsss_pkg::FIELD_W-1:0];
  endfunction

  function automatic rtsss_pkg::req_t make_req(
      input logic [rtsss_pkg::OPCODE_W-1:0] op,
      input logic [rtsss_pkg::FIELD_W-1:0]  len,
      input logic [rtsss_pkg::FIELD_W-1:0]  rf,
      input logic [rtsss_pkg::FIELD_W-1:0]  rl);
    rtsss_pkg::req_t r;
    r.opcode         = op;
    r.subfile_length = len;
    r.range_first    = rf;
    r.range_last     = rl;
    return r;
  endfunction

  // length styles: tiny, mid, full width, random magnitude; zero shows up in all
  function automatic logic [rtsss_pkg::FIELD_W-1:0] pick_length(input int unsigned style);
    logic [rtsss_pkg::FIELD_W-1:0] v;
    if ($urandom_range(0, 5) == 0) return '0;
    case (style)
      0:       v = rtsss_pkg::FIELD_W'($urandom_range(1, 40));
      1:       v = rtsss_pkg::FIELD_W'($urandom_range(1, 1 << 20));
      2:       v = rand48();
      default: v = rand48() >> $urandom_range(0, rtsss_pkg::FIELD_W - 1);
    endcase
    return v;
  endfunction

  // Table update and range split for one request; results in emit order.
  task automatic model_request(input rtsss_pkg::req_t r, output rtsss_pkg::res_t outs[$]);
    rtsss_pkg::res_t               one, seg;
    logic [rtsss_pkg::FIELD_W-1:0] seg_end, lo, hi;
    outs = {};
    one = '0;
    one.last_result = 1'b1;
    case (r.opcode)
      rtsss_pkg::OP_CLEAR: begin
        sub_count  = 0;
        byte_total = '0;
        one.status = rtsss_pkg::ST_OK;
      end
      rtsss_pkg::OP_APPEND: begin
        if (sub_count >= TABLE_DEPTH || r.subfile_length > FULL48 - byte_total) begin
          one.status = rtsss_pkg::ST_REJECT;
        end else begin
          sub_start[sub_count] = byte_total;
          sub_len[sub_count]   = r.subfile_length;
          sub_count++;
          byte_total = byte_total + r.subfile_length;
          one.status = rtsss_pkg::ST_OK;
        end
      end
      rtsss_pkg::OP_QUERY: begin
        one.status = rtsss_pkg::ST_NONE;
        if (r.range_first <= r.range_last) begin
          for (int i = 0; i < sub_count; i++) begin
            if (sub_len[i] == '0) continue;
            seg_end = sub_start[i] + (sub_len[i] - 1'b1);
            if (sub_start[i] > r.range_last) break;
            if (seg_end < r.range_first) continue;
            lo = (sub_start[i] > r.range_first) ? sub_start[i] : r.range_first;
            hi = (seg_end < r.range_last) ? seg_end : r.range_last;
            seg = '0;
            seg.status        = rtsss_pkg::ST_SEGMENT;
            seg.subfile_index = rtsss_pkg::IDX_W'(i);
            seg.segment_first = lo - sub_start[i];
            seg.segment_last  = hi - sub_start[i];
            outs.push_back(seg);
          end
        end
        if (outs.size() != 0) begin
          seg = outs.pop_back();
          seg.last_result = 1'b1;
          outs.push_back(seg);
        end
      end
      default: one.status = rtsss_pkg::ST_REJECT;
    endcase
    if (outs.size() == 0) outs.push_back(one);
  endtask

  task automatic send_req(input rtsss_pkg::req_t r, input bit typed = 1'b0,
                          input logic [rtsss_pkg::STATUS_W-1:0] st = rtsss_pkg::ST_OK);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    row_typed  <= typed;
    row_status <= st;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  // result side: stall density is redrawn each time its random hold count runs out
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(50, 300);
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 50;
        default: stall_pct = 80;
      endcase
    end
    stall_left--;
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // request accept -> predict; result accept -> check
  always @(posedge clk_i) begin : monitor
    rtsss_pkg::res_t outs[$];
    rtsss_pkg::res_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        model_request(in_req_i, outs);
        if (row_typed) begin
          want = '0;
          want.status      = row_status;
          want.last_result = 1'b1;
          outs = {want};
        end
        foreach (outs[k]) split_expect.push_back(outs[k]);
      end
      if (out_valid_o && out_ready_i) begin
        n_results++;
        case (out_res_o.status)
          rtsss_pkg::ST_SEGMENT: n_segments++;
          rtsss_pkg::ST_NONE:    n_none++;
          rtsss_pkg::ST_REJECT:  n_reject++;
          default:               ;
        endcase
        if (split_expect.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with nothing pending: status %0d idx %0d first %h last %h",
                     $realtime, out_res_o.status, out_res_o.subfile_index,
                     out_res_o.segment_first, out_res_o.segment_last);
          fail_count++;
        end else begin
          want = split_expect.pop_front();
          if (out_res_o !== want) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch exp status %0d idx %0d first %h last %h fin %0d",
                       $realtime, want.status, want.subfile_index,
                       want.segment_first, want.segment_last, want.last_result);
              $display("          got status %0d idx %0d first %h last %h fin %0d",
                       out_res_o.status, out_res_o.subfile_index,
                       out_res_o.segment_first, out_res_o.segment_last,
                       out_res_o.last_result);
            end
            fail_count++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t                      dir_rows[$];
    dir_row_t                      row;
    logic [rtsss_pkg::FIELD_W-1:0] len;
    longint unsigned               span_est, pick_a, pick_b;
    int unsigned                   len_style, n_app;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    row_typed  = 1'b0;
    row_status = rtsss_pkg::ST_OK;
    burst_left = 0;
    stall_left = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: typed rows carry an obvious status, others use the predictor
    dir_rows.push_back('{make_req(rtsss_pkg::OP_QUERY, '0, '0, FULL48),
                         1'b1, rtsss_pkg::ST_NONE});
    dir_rows.push_back('{make_req(OP_UNUSED, FULL48, FULL48, FULL48),
                         1'b1, rtsss_pkg::ST_REJECT});
    dir_rows.push_back('{make_req(rtsss_pkg::OP_APPEND, '0, '0, '0),
                         1'b1, rtsss_pkg::ST_OK});
    // only an empty subfile in the table
    dir_rows.push_back('{make_req(rtsss_pkg::OP_QUERY, '0, '0, FULL48),
                         1'b1, rtsss_pkg::ST_NONE});
    dir_rows.push_back('{make_req(rtsss_pkg::OP_APPEND, 48'd10, '0, '0),
                         1'b1, rtsss_pkg::ST_OK});
    dir_rows.push_back('{make_req(rtsss_pkg::OP_APPEND, 48'd5, '0, '0),
                         1'b1, rtsss_pkg::ST_OK});
    dir_rows.push_back('{make_req(rtsss_pkg::OP_QUERY, '0, 48'd0, 48'd14),
                         1'b0, rtsss_pkg::ST_OK});
    dir_rows.push_back('{make_req(rtsss_pkg::OP_QUERY, '0, 48'd12, 48'd100),
                         1'b0, rtsss_pkg::ST_OK});
    dir_rows.push_back('{make_req(rtsss_pkg::OP_QUERY, '0, 48'd15, FULL48),
                         1'b1, rtsss_pkg::ST_NONE});
    dir_rows.push_back('{make_req(rtsss_pkg::OP_QUERY, '0, 48'd9, 48'd3),
                         1'b1, rtsss_pkg::ST_NONE});
    // total lands exactly on the top offset, then one byte more overflows
    dir_rows.push_back('{make_req(rtsss_pkg::OP_APPEND, FULL48 - 48'd15, '0, '0),
                         1'b1, rtsss_pkg::ST_OK});
    dir_rows.push_back('{make_req(rtsss_pkg::OP_APPEND, 48'd1, '0, '0),
                         1'b1, rtsss_pkg::ST_REJECT});
    dir_rows.push_back('{make_req(rtsss_pkg::OP_APPEND, '0, '0, '0),
                         1'b1, rtsss_pkg::ST_OK});
    dir_rows.push_back('{make_req(rtsss_pkg::OP_QUERY, '0, FULL48 - 1'b1, FULL48),
                         1'b0, rtsss_pkg::ST_OK});
    repeat (TABLE_DEPTH - 5)
      dir_rows.push_back('{make_req(rtsss_pkg::OP_APPEND, '0, '0, '0),
                           1'b1, rtsss_pkg::ST_OK});
    dir_rows.push_back('{make_req(rtsss_pkg::OP_APPEND, '0, '0, '0),
                         1'b1, rtsss_pkg::ST_REJECT});
    dir_rows.push_back('{make_req(rtsss_pkg::OP_QUERY, '0, '0, FULL48),
                         1'b0, rtsss_pkg::ST_OK});

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_req(row.req, row.typed, row.want_status);
    end

    // random part: mostly clear / appends / queries, some stray requests
    while (n_sent < dir_rows.size() + RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 12) begin
        send_req(make_req(rtsss_pkg::OPCODE_W'($urandom_range(0, 3)),
                          rand48(), rand48(), rand48()));
      end else begin
        len_style = $urandom_range(0, 3);
        n_app = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 6);
        send_req(make_req(rtsss_pkg::OP_CLEAR, rand48(), rand48(), rand48()));
        span_est = 0;
        repeat (n_app) begin
          len = pick_length(len_style);
          send_req(make_req(rtsss_pkg::OP_APPEND, len, rand48(), rand48()));
          span_est += len;
          if (span_est > FULL48) span_est = FULL48;
        end
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
              pick_a = rand64() % (span_est + 1);
              pick_b = pick_a + rand64() % (span_est - pick_a + 1);
            end
            6: begin
              pick_a = rand64() % (span_est + 1);
              pick_b = pick_a + $urandom_range(0, 3);
            end
            7: begin
              pick_b = rand64() % (span_est + 1);
              pick_a = pick_b + $urandom_range(1, 64);
            end
            8: begin
              pick_a = span_est + $urandom_range(0, 16);
              pick_b = pick_a + $urandom_range(0, 1000);
            end
            default: begin
              pick_a = rand48();
              pick_b = rand48();
            end
          endcase
          send_req(make_req(rtsss_pkg::OP_QUERY, rand48(),
                            pick_a[rtsss_pkg::FIELD_W-1:0], pick_b[rtsss_pkg::FIELD_W-1:0]));
        end
      end
    end
    in_valid_i <= 1'b0;

    // let the monitor record the last accepted request first
    @(posedge clk_i);
    while (split_expect.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("%0d requests sent; %0d results checked: %0d segments, %0d no-segment, %0d rejects",
             n_sent, n_results, n_segments, n_none, n_reject);
    if (fail_count == 0 && split_expect.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches, %0d results still pending", fail_count, split_expect.size());
      $display("tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("timeout with %0d results pending", split_expect.size());
    $display("tb failed");
    $finish;
  end

endmodule
